[rtl/tcr_pkg.sv]
// Shared types and codes for the thin-plate-spline colour remapper.
`default_nettype none
package tcr_pkg;

	// Request kinds carried in the mode field
	localparam logic [1:0] MODE_PIXEL  = 2'd0;
	localparam logic [1:0] MODE_POINT  = 2'd1;
	localparam logic [1:0] MODE_AFFINE = 2'd2;
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	localparam int CHANNELS  = 3;
	localparam int AFF_ROWS  = 4;
	localparam int COEF_W    = 32;
	localparam int COORD_W   = 16;

	typedef struct packed {
		logic [1:0]         mode;
		logic [6:0]         index;
		logic [7:0]         pixel_red;
		logic [7:0]         pixel_green;
		logic [7:0]         pixel_blue;
		logic [15:0]        coord_0;
		logic [15:0]        coord_1;
		logic [15:0]        coord_2;
		logic signed [31:0] coef_0;
		logic signed [31:0] coef_1;
		logic signed [31:0] coef_2;
	} tcr_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       clipped;
	} tcr_out_t;

endpackage
`default_nettype wire

[rtl/tcr_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tcr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/tcr_root_cell.sv]
// One digit cell of the pipelined integer square-root chain.
`default_nettype none
module tcr_root_cell #(
	parameter int RN  = 17,
	parameter int PLW = 96
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            v_i,
	input  wire logic [2*RN-1:0] rad_i,
	input  wire logic [RN+1:0]   rem_i,
	input  wire logic [RN-1:0]   root_i,
	input  wire logic [PLW-1:0]  pl_i,
	output logic                 v_o,
	output logic      [2*RN-1:0] rad_o,
	output logic      [RN+1:0]   rem_o,
	output logic      [RN-1:0]   root_o,
	output logic      [PLW-1:0]  pl_o
);

	logic [RN+3:0] tmp;
	logic [RN+3:0] trial;
	logic [RN+3:0] diff;
	logic          ge;
	logic [RN:0]   root_sh;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		tmp     = {rem_i, rad_i[2*RN-1 -: 2]};
		trial   = {2'b00, root_i, 2'b01};
		ge      = (tmp >= trial);
		diff    = ge ? (tmp - trial) : tmp;
		root_sh = {root_i, ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		rad_o  <= rad_i << 2;
		rem_o  <= diff[RN+1:0];
		root_o <= root_sh[RN-1:0];
		pl_o   <= pl_i;
	end

endmodule
`default_nettype wire

[rtl/tps_colour_remap.sv]
// Top level: thin-plate-spline colour remapper with a square-root cell chain.
// Load requests (control point or affine row) are written while idle and leave the block idle.
// A pixel steps through the affine, point-issue, drain and finish states, with a square-root chain
// of RN = max(8+COORD_FRAC_BITS,16)+1 root cells.
// The shared affine multiplier serves the affine terms, then the point RAM is read once per active point.
// One pixel is in flight at a time; the output register frees the input side.
// Reset clears control state, active_points and the affine rows; the point RAMs are not cleared.
`default_nettype none
module tps_colour_remap
	import tcr_pkg::*;
#(
	parameter int MAX_POINTS      = 128,
	parameter int COORD_FRAC_BITS = 8,
	parameter int COEF_FRAC_BITS  = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire tcr_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output tcr_out_t     out_data,
	input  wire logic    cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	localparam int C    = COORD_FRAC_BITS;
	localparam int SH   = COORD_FRAC_BITS + COEF_FRAC_BITS;
	localparam int PW   = (8 + C > COORD_W) ? 8 + C : COORD_W;
	localparam int DW   = PW + 1;
	localparam int SQW  = 2 * PW;
	localparam int RN   = PW + 1;
	localparam int SW   = 2 * RN;
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int ACCW = 64;
	localparam int WW   = CHANNELS * COEF_W;
	localparam int PRW  = RN + 1 + COEF_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_AFFINE, ST_POINTS, ST_DRAIN, ST_FINISH
	} state_t;

	state_t state_q;
	logic [7:0] active_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] row_q;
	logic [1:0] col_q;
	logic [7:0] px_q [CHANNELS];
	logic signed [COEF_W-1:0] aff_q [AFF_ROWS*CHANNELS];
	logic signed [ACCW-1:0] acc_q [CHANNELS];
	logic out_valid_q;
	tcr_out_t out_q;

	logic in_acc;
	logic issue_v;
	logic busy;
	logic out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 8'd0;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// point and weight RAMs, written by control-point load requests
	logic pt_we;
	logic [AW-1:0] pt_waddr;
	logic [3*COORD_W-1:0] pt_rdata;
	logic [WW-1:0] wt_rdata;

	assign pt_we    = in_acc && (in_data.mode == MODE_POINT) &&
		({2'b00, in_data.index} < 9'(MAX_POINTS));
	assign pt_waddr = AW'(in_data.index);

	tcr_ram #(.WIDTH(3*COORD_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata ({in_data.coord_2, in_data.coord_1, in_data.coord_0}),
		.raddr (cnt_q[AW-1:0]),
		.rdata (pt_rdata)
	);

	tcr_ram #(.WIDTH(WW), .DEPTH(MAX_POINTS)) u_wt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata ({in_data.coef_2, in_data.coef_1, in_data.coef_0}),
		.raddr (cnt_q[AW-1:0]),
		.rdata (wt_rdata)
	);

	// affine rows, reset to zero
	logic [3:0] aff_wbase;
	assign aff_wbase = 4'(in_data.index[1:0]) * 4'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AFF_ROWS*CHANNELS; i++) begin
				aff_q[i] <= '0;
			end
		end else if (in_acc && (in_data.mode == MODE_AFFINE) && (in_data.index < 7'd4)) begin
			aff_q[aff_wbase]        <= in_data.coef_0;
			aff_q[aff_wbase + 4'd1] <= in_data.coef_1;
			aff_q[aff_wbase + 4'd2] <= in_data.coef_2;
		end
	end

	// point issue
	assign issue_v = (state_q == ST_POINTS) && (cnt_q < n_q);

	// stage 1: RAM read data
	logic v_s1;
	// stage 2: squared differences
	logic v_s2;
	logic [SQW-1:0] sq_s2 [CHANNELS];
	logic [WW-1:0] w_s2;
	// stage 3: squared distance
	logic v_s3;
	logic [SW-1:0] rad_s3;
	logic [WW-1:0] w_s3;
	// stage 4: spline products
	logic v_s4;
	logic signed [PRW-1:0] prod_s4 [CHANNELS];

	logic signed [DW-1:0] dif [CHANNELS];
	logic signed [2*DW-1:0] sq_full [CHANNELS];

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			dif[k] = $signed(DW'(px_q[k]) << C) -
				$signed(DW'(pt_rdata[k*COORD_W +: COORD_W]));
			sq_full[k] = dif[k] * dif[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CHANNELS; k++) begin
			sq_s2[k] <= sq_full[k][SQW-1:0];
		end
		w_s2   <= wt_rdata;
		rad_s3 <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
		w_s3   <= w_s2;
	end

	// square-root cell chain, one root bit per cell
	logic          ch_v    [RN+1];
	logic [SW-1:0] ch_rad  [RN+1];
	logic [RN+1:0] ch_rem  [RN+1];
	logic [RN-1:0] ch_root [RN+1];
	logic [WW-1:0] ch_pl   [RN+1];

	assign ch_v[0]    = v_s3;
	assign ch_rad[0]  = rad_s3;
	assign ch_rem[0]  = '0;
	assign ch_root[0] = '0;
	assign ch_pl[0]   = w_s3;

	for (genvar g = 0; g < RN; g++) begin : g_cell
		tcr_root_cell #(.RN(RN), .PLW(WW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_i    (ch_v[g]),
			.rad_i  (ch_rad[g]),
			.rem_i  (ch_rem[g]),
			.root_i (ch_root[g]),
			.pl_i   (ch_pl[g]),
			.v_o    (ch_v[g+1]),
			.rad_o  (ch_rad[g+1]),
			.rem_o  (ch_rem[g+1]),
			.root_o (ch_root[g+1]),
			.pl_o   (ch_pl[g+1])
		);
	end

	logic chain_busy;
	always_comb begin
		chain_busy = 1'b0;
		for (int g = 1; g <= RN; g++) begin
			chain_busy = chain_busy | ch_v[g];
		end
	end

	// distance times weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= ch_v[RN];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CHANNELS; k++) begin
			prod_s4[k] <= $signed({1'b0, ch_root[RN]}) *
				$signed(ch_pl[RN][k*COEF_W +: COEF_W]);
		end
	end

	assign busy = v_s1 | v_s2 | v_s3 | chain_busy | v_s4;

	// shared affine multiplier
	logic [3:0] aff_ridx;
	logic signed [COEF_W-1:0] aff_coef;
	logic [7:0] aff_mul;
	logic signed [COEF_W+8:0] aff_prod;

	always_comb begin
		aff_ridx = 4'(row_q) * 4'd3 + 4'(col_q);
		aff_coef = aff_q[aff_ridx];
		aff_mul  = (row_q == 2'd0) ? 8'd1 : px_q[row_q - 2'd1];
		aff_prod = aff_coef * $signed({1'b0, aff_mul});
	end

	// accumulators and pixel hold
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q[0] <= in_data.pixel_red;
			px_q[1] <= in_data.pixel_green;
			px_q[2] <= in_data.pixel_blue;
			for (int k = 0; k < CHANNELS; k++) begin
				acc_q[k] <= '0;
			end
		end else if (state_q == ST_AFFINE) begin
			acc_q[col_q] <= acc_q[col_q] + (ACCW'(aff_prod) <<< C);
		end else if (v_s4) begin
			for (int k = 0; k < CHANNELS; k++) begin
				acc_q[k] <= acc_q[k] - ACCW'(prod_s4[k]);
			end
		end
	end

	// round half up and saturate
	logic signed [ACCW-1:0] rnd [CHANNELS];
	logic signed [ACCW-1:0] quo [CHANNELS];
	logic [7:0] res [CHANNELS];
	logic sat;

	always_comb begin
		sat = 1'b0;
		for (int k = 0; k < CHANNELS; k++) begin
			rnd[k] = acc_q[k] + (ACCW'(1) <<< (SH - 1));
			quo[k] = rnd[k] >>> SH;
			if (rnd[k][ACCW-1]) begin
				res[k] = 8'd0;
				sat    = 1'b1;
			end else if (quo[k] > ACCW'(255)) begin
				res[k] = 8'd255;
				sat    = 1'b1;
			end else begin
				res[k] = quo[k][7:0];
			end
		end
	end

	// sequencer and output register
	logic [8:0] n_lim;
	assign n_lim = ({1'b0, active_q} > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : {1'b0, active_q};

	// result enters the output register when it is empty or being drained
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			cnt_q       <= '0;
			row_q       <= 2'd0;
			col_q       <= 2'd0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_data.mode == MODE_PIXEL)) begin
						n_q     <= CW'(n_lim);
						cnt_q   <= '0;
						row_q   <= 2'd0;
						col_q   <= 2'd0;
						state_q <= ST_AFFINE;
					end
				end
				ST_AFFINE: begin
					if (col_q == 2'd2) begin
						col_q <= 2'd0;
						if (row_q == 2'd3) begin
							state_q <= ST_POINTS;
						end else begin
							row_q <= row_q + 2'd1;
						end
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				ST_POINTS: begin
					if (issue_v) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						out_q.out_red   <= res[0];
						out_q.out_green <= res[1];
						out_q.out_blue  <= res[2];
						out_q.clipped   <= sat;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// no point still in flight once a new request may enter
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !busy)
		else $error("point pipeline busy while idle");

	// points are read only while issuing
	a_issue_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == ST_POINTS))
		else $error("point read outside issue phase");

	// issue count never passes the point count
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POINTS || state_q == ST_DRAIN) |-> (cnt_q <= n_q))
		else $error("point counter overran");

	// a result is produced only from the finish phase
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result without finish");
`endif

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Testbench for tps_colour_remap: directed table plus random requests, checked against a predictor.
`default_nettype none
module tb_top;
	import tcr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS     = 128;
	localparam int SHIFT    = 24;   // coord + coef fraction bits
	localparam int WD_LIMIT = 20000;
	localparam int DRAIN    = 300;  // longer than one pixel takes for any point count

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	tcr_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	tcr_out_t out_data;
	logic     cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	always #1 clk = ~clk;

	tps_colour_remap uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the block state
	logic [15:0] pt_coord [NPTS][3];
	longint      pt_weight [NPTS][3];
	longint      aff_coef [12];
	int          active_cnt;

	tcr_out_t pixel_q [$];
	int       fails = 0;
	bit       quiet = 1'b0;
	bit       hold_req = 1'b0;
	bit       in_fire, out_fire;
	int       prev_active = 0;

	// Floor of the square root, one result bit per pass
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned t;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic tcr_out_t remap_pixel(tcr_in_t rq);
		longint pix [3];
		longint acc [3];
		longint d, r, q;
		longint unsigned s, span;
		int n;
		logic [7:0] res [3];
		bit sat = 0;
		tcr_out_t o;
		pix[0] = rq.pixel_red;
		pix[1] = rq.pixel_green;
		pix[2] = rq.pixel_blue;
		for (int k = 0; k < 3; k++)
			acc[k] = (aff_coef[k] + aff_coef[3+k] * pix[0] + aff_coef[6+k] * pix[1]
				+ aff_coef[9+k] * pix[2]) * 256;
		n = (active_cnt > NPTS) ? NPTS : active_cnt;
		for (int j = 0; j < n; j++) begin
			s = 0;
			for (int k = 0; k < 3; k++) begin
				d = pix[k] * 256 - longint'(pt_coord[j][k]);
				s += longint'(d * d);
			end
			span = root_floor(s);
			for (int k = 0; k < 3; k++)
				acc[k] -= longint'(span) * pt_weight[j][k];
		end
		// round half up, then clamp
		for (int k = 0; k < 3; k++) begin
			r = acc[k] + (64'sd1 <<< (SHIFT - 1));
			q = r >>> SHIFT;
			if (r < 0) begin
				res[k] = 8'd0;
				sat = 1;
			end else if (q > 255) begin
				res[k] = 8'd255;
				sat = 1;
			end else
				res[k] = q[7:0];
		end
		o.out_red = res[0];
		o.out_green = res[1];
		o.out_blue = res[2];
		o.clipped = sat;
		return o;
	endfunction

	// Update the shadow state for an accepted request; pixels queue a result
	function automatic void absorb_request(tcr_in_t rq);
		case (rq.mode)
			MODE_POINT: begin
				pt_coord[rq.index] = '{rq.coord_0, rq.coord_1, rq.coord_2};
				pt_weight[rq.index] = '{longint'(rq.coef_0), longint'(rq.coef_1),
					longint'(rq.coef_2)};
			end
			MODE_AFFINE: begin
				if (rq.index < AFF_ROWS) begin
					aff_coef[rq.index*3]   = rq.coef_0;
					aff_coef[rq.index*3+1] = rq.coef_1;
					aff_coef[rq.index*3+2] = rq.coef_2;
				end
			end
			MODE_PIXEL: pixel_q = {pixel_q, remap_pixel(rq)};
			default: ;
		endcase
	endfunction

	function automatic tcr_in_t mk(logic [1:0] m, logic [6:0] ix, logic [7:0] r, logic [7:0] g,
		logic [7:0] b, logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
		tcr_in_t x;
		x = '0;
		x.mode = m;
		x.index = ix;
		x.pixel_red = r;
		x.pixel_green = g;
		x.pixel_blue = b;
		x.coef_0 = w0;
		x.coef_1 = w1;
		x.coef_2 = w2;
		return x;
	endfunction

	function automatic logic [31:0] rand_coef();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return 32'($urandom_range(0, 262143)) - 32'd131072;
	endfunction

	function automatic tcr_in_t rand_request();
		tcr_in_t x;
		int p;
		x.index = $urandom;
		x.pixel_red = $urandom;
		x.pixel_green = $urandom;
		x.pixel_blue = $urandom;
		x.coord_0 = $urandom;
		x.coord_1 = $urandom;
		x.coord_2 = $urandom;
		x.coef_0 = rand_coef();
		x.coef_1 = rand_coef();
		x.coef_2 = rand_coef();
		p = $urandom_range(0, 99);
		if (p < 72)
			x.mode = MODE_PIXEL;
		else if (p < 87)
			x.mode = MODE_POINT;
		else if (p < 95) begin
			x.mode = MODE_AFFINE;
			if ($urandom_range(0, 3) != 0)
				x.index = $urandom_range(0, AFF_ROWS - 1);
		end else
			x.mode = MODE_SPARE;
		return x;
	endfunction

	// Handshake flags, sampled mid-cycle so the next rising edge is the transfer
	always @(negedge clk) begin
		in_fire = in_valid && in_ready;
		out_fire = out_valid && out_ready;
	end

	// Offer one request and return on the edge that takes it
	task automatic send(tcr_in_t rq);
		while (!quiet && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= rq;
		do @(negedge clk); while (!(in_valid && in_ready));
		@(posedge clk);
		absorb_request(rq);
	endtask

	// Wait until idle, then write the point count
	task automatic set_points(int n);
		in_valid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 8'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		active_cnt = n;
	endtask

	task automatic random_phase(int cnt, int pts);
		set_points(pts);
		for (int i = 0; i < cnt; i++)
			send(rand_request());
	endtask

	// Result side: random back-pressure plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			out_ready <= 1'b0;
			for (int c = 0; c < 400; c++)
				@(posedge clk);
			hold_req = 1'b0;
		end else
			out_ready <= quiet || ($urandom_range(0, 99) >= 20);
	end

	// Result check against the oldest expectation
	always @(negedge clk) begin
		tcr_out_t e;
		if (out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected result %h", out_data);
				fails++;
			end else begin
				e = pixel_q.pop_front();
				if (out_data.out_red !== e.out_red) begin
					$error("out_red exp %0d got %0d", e.out_red, out_data.out_red);
					fails++;
				end
				if (out_data.out_green !== e.out_green) begin
					$error("out_green exp %0d got %0d", e.out_green, out_data.out_green);
					fails++;
				end
				if (out_data.out_blue !== e.out_blue) begin
					$error("out_blue exp %0d got %0d", e.out_blue, out_data.out_blue);
					fails++;
				end
				if (out_data.clipped !== e.clipped) begin
					$error("clipped exp %0d got %0d", e.clipped, out_data.clipped);
					fails++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (in_fire || out_fire || cfg_we)
			idle_cycles <= 0;
		else if (idle_cycles >= WD_LIMIT) begin
			$display("tps_colour_remap test failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	typedef struct {
		tcr_in_t  rq;
		bit       typed;
		tcr_out_t res;
	} row_t;

	row_t table_rows [$];

	initial begin
		tcr_out_t z;
		z = '0;
		for (int i = 0; i < 12; i++)
			aff_coef[i] = 0;
		active_cnt = 0;
		// Directed rows; typed results where they follow at a glance
		table_rows = '{
			'{mk(MODE_PIXEL, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0}},
			'{mk(MODE_PIXEL, 7'h7f, 255, 255, 255, '1, '1, '1), 1, '{0, 0, 0, 0}},
			'{mk(MODE_AFFINE, 0, 0, 0, 0, 32'd255 << 16, 32'h7fffffff, 32'h80000000), 0, z},
			'{mk(MODE_PIXEL, 0, 9, 9, 9, 0, 0, 0), 1, '{255, 255, 0, 1}},
			'{mk(MODE_AFFINE, 0, 0, 0, 0, 0, 0, 0), 0, z},
			'{mk(MODE_AFFINE, 1, 0, 0, 0, 32'h10000, 0, 0), 0, z},
			'{mk(MODE_PIXEL, 0, 255, 128, 7, 0, 0, 0), 1, '{255, 0, 0, 0}},
			'{mk(MODE_AFFINE, 2, 0, 0, 0, 0, 32'h10000, 0), 0, z},
			'{mk(MODE_AFFINE, 3, 0, 0, 0, 0, 0, 32'h8000), 0, z},
			'{mk(MODE_PIXEL, 0, 0, 200, 3, 0, 0, 0), 1, '{0, 200, 2, 0}},
			'{mk(MODE_AFFINE, 5, 0, 0, 0, '1, '1, '1), 0, z},
			'{mk(MODE_SPARE, 7'h55, 1, 2, 3, '1, '1, '1), 0, z},
			'{mk(MODE_PIXEL, 0, 10, 20, 1, 0, 0, 0), 1, '{10, 20, 1, 0}},
			'{mk(MODE_AFFINE, 3, 0, 0, 0, 32'hffff0000, 32'hffff0000, 32'hffff0000), 0, z},
			'{mk(MODE_PIXEL, 0, 4, 5, 6, 0, 0, 0), 0, z},
			'{mk(MODE_AFFINE, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h00008000), 0, z},
			'{mk(MODE_PIXEL, 0, 255, 0, 255, 0, 0, 0), 0, z}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_points(0);
		foreach (table_rows[i]) begin
			send(table_rows[i].rq);
			if (table_rows[i].typed)
				pixel_q[$] = table_rows[i].res;
		end

		// Fill every control point slot before any is read
		for (int j = 0; j < NPTS; j++) begin
			tcr_in_t p;
			p = rand_request();
			p.mode = MODE_POINT;
			p.index = j;
			send(p);
		end

		random_phase(250, 1);
		random_phase(150, NPTS);
		random_phase(60, 255);
		quiet = 1'b1;
		random_phase(200, 3);
		quiet = 1'b0;

		// Long receiver hold-off while requests keep coming, then a full drain
		set_points(6);
		for (int i = 0; i < 200; i++) begin
			if (i == 20)
				hold_req = 1'b1;
			if (i == 120) begin
				in_valid <= 1'b0;
				wait (pixel_q.size() == 0);
				@(posedge clk);
			end
			send(rand_request());
		end

		for (int ph = 0; ph < 4; ph++)
			random_phase(130, $urandom_range(0, 20));

		in_valid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0)
			$display("tps_colour_remap test passed");
		else
			$display("tps_colour_remap test failed");
		$finish;
	end
endmodule
`default_nettype wire
